@@ hdl/segment_plane_checker_hit_assert.svh @@
// assertion macros for the segment plane checker checks
`ifndef SEGMENT_PLANE_CHECKER_HIT_ASSERT_SVH
`define SEGMENT_PLANE_CHECKER_HIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("spc assertion failed");

// consequent holds in the cycle after the antecedent
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("spc assertion failed");

`endif

@@ hdl/spc_pkg.sv @@
// shared constants and types of the segment plane checker
package spc_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_IDX_W         = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X,
    CFG_COEF_Y,
    CFG_COEF_Z,
    CFG_OFFSET,
    CFG_SQUARE_SIZE,
    CFG_HOLE_PARITY
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic crossed;
    logic start_inside;
  } ctl_t;

endpackage

@@ hdl/spc_plane.sv @@
// plane evaluation at both endpoints: products, sums, signs and magnitudes
module spc_plane import spc_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int F  = FRACTION_BITS_DEF,
  parameter int DW = 2*COORD_WIDTH_DEF+3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][W-1:0]   coef,
  input  logic [W-1:0]        offset,
  input  logic [2:0][W-1:0]   pt_p,
  input  logic [2:0][W-1:0]   pt_q,
  output ctl_t                ctl_o,
  output logic [DW-1:0]       a1_o,
  output logic [DW-1:0]       den_o,
  output logic [2:0][W:0]     ud_o,
  output logic [2:0]          neg_o,
  output logic [2:0][W-1:0]   p_o
);

  // stage 1: products
  logic                    v1_r;
  logic signed [2*W-1:0]   prodp_r [3];
  logic signed [2*W-1:0]   prodq_r [3];
  logic signed [DW-1:0]    offs_r;
  logic [2:0][W-1:0]       p1_r;
  logic [2:0][W-1:0]       q1_r;

  // stage 2: sums and deltas
  logic                    v2_r;
  logic signed [DW-1:0]    d1_r;
  logic signed [DW-1:0]    d2_r;
  logic signed [W:0]       dl_r [3];
  logic [2:0][W-1:0]       p2_r;

  // stage 3
  ctl_t                    ctl_r;
  logic [DW-1:0]           a1_r;
  logic [DW-1:0]           den_r;
  logic [2:0][W:0]         ud_r;
  logic [2:0]              neg_r;
  logic [2:0][W-1:0]       p3_r;

  logic                    n1, n2, z1, z2;
  ctl_t                    ctl_nxt;
  logic [DW-1:0]           a1_nxt;
  logic [DW-1:0]           den_nxt;
  logic [2:0][W:0]         ud_nxt;
  logic [2:0]              neg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ctl_r <= '0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prodp_r[i] <= $signed(coef[i]) * $signed(pt_p[i]);
        prodq_r[i] <= $signed(coef[i]) * $signed(pt_q[i]);
        dl_r[i]    <= (W+1)'($signed(q1_r[i])) - (W+1)'($signed(p1_r[i]));
      end
      offs_r <= DW'($signed(offset)) <<< F;
      p1_r   <= pt_p;
      q1_r   <= pt_q;
      d1_r   <= DW'(prodp_r[0]) + DW'(prodp_r[1]) + DW'(prodp_r[2]) + offs_r;
      d2_r   <= DW'(prodq_r[0]) + DW'(prodq_r[1]) + DW'(prodq_r[2]) + offs_r;
      p2_r   <= p1_r;
      a1_r   <= a1_nxt;
      den_r  <= den_nxt;
      ud_r   <= ud_nxt;
      neg_r  <= neg_nxt;
      p3_r   <= p2_r;
    end
  end

  always_comb begin
    n1 = d1_r[DW-1];
    n2 = d2_r[DW-1];
    z1 = (d1_r == '0);
    z2 = (d2_r == '0);
    ctl_nxt.valid        = v2_r;
    ctl_nxt.crossed      = (n1 && !n2 && !z2) || (!n1 && !z1 && n2);
    ctl_nxt.start_inside = n1 || z1;
    a1_nxt  = n1 ? DW'(-d1_r) : DW'(d1_r);
    // only meaningful when the signs differ: then |d1|+|d2| = |d1-d2|
    den_nxt = n1 ? DW'(d2_r - d1_r) : DW'(d1_r - d2_r);
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = dl_r[i][W];
      ud_nxt[i]  = dl_r[i][W] ? (W+1)'(-dl_r[i]) : (W+1)'(dl_r[i]);
    end
  end

  assign ctl_o = ctl_r;
  assign a1_o  = a1_r;
  assign den_o = den_r;
  assign ud_o  = ud_r;
  assign neg_o = neg_r;
  assign p_o   = p3_r;

endmodule

@@ hdl/spc_cut_step.sv @@
// one radix step of the crossing-point division, three axes side by side
module spc_cut_step import spc_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int DW = 2*COORD_WIDTH_DEF+3,
  parameter int AW = 2*COORD_WIDTH_DEF+6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ctl_t                ctl_i,
  input  logic [2:0][AW-1:0]  ar_i,
  input  logic [2:0][W:0]     aq_i,
  input  logic [2:0][W:0]     ud_i,
  input  logic [2:0]          neg_i,
  input  logic [2:0][W-1:0]   p_i,
  input  logic [DW-1:0]       a1_i,
  input  logic [DW-1:0]       den_i,
  output ctl_t                ctl_o,
  output logic [2:0][AW-1:0]  ar_o,
  output logic [2:0][W:0]     aq_o,
  output logic [2:0][W:0]     ud_o,
  output logic [2:0]          neg_o,
  output logic [2:0][W-1:0]   p_o,
  output logic [DW-1:0]       a1_o,
  output logic [DW-1:0]       den_o
);

  ctl_t                ctl_r;
  logic [2:0][AW-1:0]  ar_r;
  logic [2:0][W:0]     aq_r;
  logic [2:0][W:0]     ud_r;
  logic [2:0]          neg_r;
  logic [2:0][W-1:0]   p_r;
  logic [DW-1:0]       a1_r;
  logic [DW-1:0]       den_r;

  logic [2:0][AW-1:0]  t;
  logic [2:0][AW-1:0]  s1;
  logic [2:0][AW-1:0]  s2;
  logic [2:0][1:0]     dig;
  logic [2:0][AW-1:0]  ar_nxt;
  logic [2:0][W:0]     aq_nxt;

  // remainder stays below den, so the new partial value is below 3*den
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]  = {ar_i[i][AW-2:0], 1'b0} + (ud_i[i][W] ? AW'(a1_i) : AW'(0));
      s1[i] = t[i] - AW'(den_i);
      s2[i] = t[i] - (AW'(den_i) << 1);
      priority if (!s2[i][AW-1]) begin
        ar_nxt[i] = s2[i];
        dig[i]    = 2'd2;
      end else if (!s1[i][AW-1]) begin
        ar_nxt[i] = s1[i];
        dig[i]    = 2'd1;
      end else begin
        ar_nxt[i] = t[i];
        dig[i]    = 2'd0;
      end
      aq_nxt[i] = {aq_i[i][W-1:0], 1'b0} + (W+1)'(dig[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar_r  <= ar_nxt;
      aq_r  <= aq_nxt;
      for (int i = 0; i < 3; i++) begin
        ud_r[i] <= {ud_i[i][W-1:0], 1'b0};
      end
      neg_r <= neg_i;
      p_r   <= p_i;
      a1_r  <= a1_i;
      den_r <= den_i;
    end
  end

  assign ctl_o = ctl_r;
  assign ar_o  = ar_r;
  assign aq_o  = aq_r;
  assign ud_o  = ud_r;
  assign neg_o = neg_r;
  assign p_o   = p_r;
  assign a1_o  = a1_r;
  assign den_o = den_r;

endmodule

@@ hdl/spc_round.sv @@
// crossing point: offset from start, truncation toward zero, magnitude split
module spc_round import spc_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int AW = 2*COORD_WIDTH_DEF+6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ctl_t                ctl_i,
  input  logic [2:0][AW-1:0]  ar_i,
  input  logic [2:0][W:0]     aq_i,
  input  logic [2:0]          neg_i,
  input  logic [2:0][W-1:0]   p_i,
  output ctl_t                ctl_o,
  output logic [2:0][W-1:0]   c_o,
  output logic [2:0][W-1:0]   mag_o,
  output logic [2:0]          sgn_o
);

  ctl_t                  ctl1_r, ctl2_r, ctl3_r;
  logic signed [W+1:0]   n_r [3];
  logic [2:0]            nz_r;
  logic [2:0]            neg1_r;
  logic [2:0][W-1:0]     c2_r;
  logic [2:0][W-1:0]     c3_r;
  logic [2:0][W-1:0]     mag_r;
  logic [2:0]            sgn_r;

  logic signed [W+1:0]   n_nxt [3];
  logic [2:0][W-1:0]     c_nxt;
  logic signed [W+1:0]   step [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = neg_i[i] ? (W+2)'($signed(p_i[i])) - $signed({1'b0, aq_i[i]})
                          : (W+2)'($signed(p_i[i])) + $signed({1'b0, aq_i[i]});
      // a leftover fraction pulls a point that crossed zero back toward it
      priority if (nz_r[i] && !neg1_r[i] && n_r[i][W+1]) begin
        step[i] = (W+2)'(1);
      end else if (nz_r[i] && neg1_r[i] && !n_r[i][W+1] && n_r[i] != '0) begin
        step[i] = -(W+2)'(1);
      end else begin
        step[i] = '0;
      end
      c_nxt[i] = W'(n_r[i] + step[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i]   <= n_nxt[i];
        nz_r[i]  <= (ar_i[i] != '0);
        mag_r[i] <= c2_r[i][W-1] ? W'(-c2_r[i]) : c2_r[i];
        sgn_r[i] <= c2_r[i][W-1];
      end
      neg1_r <= neg_i;
      c2_r   <= c_nxt;
      c3_r   <= c2_r;
    end
  end

  assign ctl_o = ctl3_r;
  assign c_o   = c3_r;
  assign mag_o = mag_r;
  assign sgn_o = sgn_r;

endmodule

@@ hdl/spc_par_step.sv @@
// one restoring step of the checker square division, three axes side by side
module spc_par_step import spc_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [W-2:0]        sq,
  input  ctl_t                ctl_i,
  input  logic [2:0][W-1:0]   u_i,
  input  logic [2:0][W-2:0]   r_i,
  input  logic [2:0]          sgn_i,
  input  logic [2:0][W-1:0]   c_i,
  output ctl_t                ctl_o,
  output logic [2:0][W-1:0]   u_o,
  output logic [2:0][W-2:0]   r_o,
  output logic [2:0]          qb_o,
  output logic [2:0]          sgn_o,
  output logic [2:0][W-1:0]   c_o
);

  ctl_t                ctl_r;
  logic [2:0][W-1:0]   u_r;
  logic [2:0][W-2:0]   r_r;
  logic [2:0]          qb_r;
  logic [2:0]          sgn_r;
  logic [2:0][W-1:0]   c_r;

  logic [2:0][W-1:0]   t;
  logic [2:0][W:0]     diff;
  logic [2:0][W-2:0]   r_nxt;
  logic [2:0]          qb_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]      = {r_i[i], u_i[i][W-1]};
      diff[i]   = {1'b0, t[i]} - {2'b00, sq};
      qb_nxt[i] = !diff[i][W];
      r_nxt[i]  = qb_nxt[i] ? diff[i][W-2:0] : t[i][W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= {u_i[i][W-2:0], 1'b0};
      end
      r_r   <= r_nxt;
      qb_r  <= qb_nxt;
      sgn_r <= sgn_i;
      c_r   <= c_i;
    end
  end

  assign ctl_o = ctl_r;
  assign u_o   = u_r;
  assign r_o   = r_r;
  assign qb_o  = qb_r;
  assign sgn_o = sgn_r;
  assign c_o   = c_r;

endmodule

@@ hdl/segment_plane_checker_hit.sv @@
// segment_plane_checker_hit: segment against checkerboard plane, one test per clock unless the output stalls
// Takes one segment per clock while in_tready is high and returns one result per
// segment, in order. The pipeline is plane evaluation, COORD_WIDTH+1 radix steps
// that divide out the crossing point, rounding, COORD_WIDTH steps that divide each
// crossing coordinate by the square size for its parity, and one output register.
// A skid register after the output lets one more item in while a result waits, and
// the whole pipeline holds while the skid is occupied; otherwise throughput stays at
// one item per cycle. Configuration is taken at once and must only be written while
// no item is in flight; the normal fields echo the live coefficients.
module segment_plane_checker_hit import spc_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // start_x, start_y, start_z, end_x, end_y, end_z from bit 0 up, zero padded
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // crossed, hit, start_inside, cross_x, cross_y, cross_z, normal_x, normal_y,
  // normal_z from bit 0 up, zero padded
  output logic [((6*COORD_WIDTH+10)/8)*8-1:0]  out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = ((2*W > W+FRACTION_BITS) ? 2*W : W+FRACTION_BITS) + 3;
  localparam int AW    = DW + 3;
  localparam int ND    = W + 1;
  localparam int NP    = W;
  localparam int OUT_W = ((6*W+10)/8)*8;

  // configuration registers
  logic [W-1:0]   cx_r, cy_r, cz_r, off_r;
  logic [W-2:0]   sq_r;
  logic           par_r;
  logic [W-2:0]   sq_eff;

  logic           en;
  logic [2:0][W-1:0] pt_p, pt_q, coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= W'(1) << FRACTION_BITS;
      off_r <= '0;
      sq_r  <= (W-1)'(1) << FRACTION_BITS;
      par_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_COEF_X:      cx_r  <= cfg_data;
        CFG_COEF_Y:      cy_r  <= cfg_data;
        CFG_COEF_Z:      cz_r  <= cfg_data;
        CFG_OFFSET:      off_r <= cfg_data;
        CFG_SQUARE_SIZE: sq_r  <= cfg_data[W-2:0];
        CFG_HOLE_PARITY: par_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign sq_eff    = (sq_r == '0) ? (W-1)'(1) : sq_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_p[i] = in_tdata[i*W +: W];
      pt_q[i] = in_tdata[(3+i)*W +: W];
    end
    coef[0] = cx_r;
    coef[1] = cy_r;
    coef[2] = cz_r;
  end

  // plane evaluation
  ctl_t               cut_ctl [ND+1];
  logic [2:0][AW-1:0] cut_ar  [ND+1];
  logic [2:0][W:0]    cut_aq  [ND+1];
  logic [2:0][W:0]    cut_ud  [ND+1];
  logic [2:0]         cut_neg [ND+1];
  logic [2:0][W-1:0]  cut_p   [ND+1];
  logic [DW-1:0]      cut_a1  [ND+1];
  logic [DW-1:0]      cut_den [ND+1];

  spc_plane #(.W(W), .F(FRACTION_BITS), .DW(DW)) u_plane (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .coef     (coef),
    .offset   (off_r),
    .pt_p     (pt_p),
    .pt_q     (pt_q),
    .ctl_o    (cut_ctl[0]),
    .a1_o     (cut_a1[0]),
    .den_o    (cut_den[0]),
    .ud_o     (cut_ud[0]),
    .neg_o    (cut_neg[0]),
    .p_o      (cut_p[0])
  );

  assign cut_ar[0] = '0;
  assign cut_aq[0] = '0;

  // crossing point division, one quotient digit per stage
  for (genvar g = 0; g < ND; g++) begin : g_cut
    spc_cut_step #(.W(W), .DW(DW), .AW(AW)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (cut_ctl[g]),
      .ar_i  (cut_ar[g]),
      .aq_i  (cut_aq[g]),
      .ud_i  (cut_ud[g]),
      .neg_i (cut_neg[g]),
      .p_i   (cut_p[g]),
      .a1_i  (cut_a1[g]),
      .den_i (cut_den[g]),
      .ctl_o (cut_ctl[g+1]),
      .ar_o  (cut_ar[g+1]),
      .aq_o  (cut_aq[g+1]),
      .ud_o  (cut_ud[g+1]),
      .neg_o (cut_neg[g+1]),
      .p_o   (cut_p[g+1]),
      .a1_o  (cut_a1[g+1]),
      .den_o (cut_den[g+1])
    );
  end

  ctl_t              par_ctl [NP+1];
  logic [2:0][W-1:0] par_u   [NP+1];
  logic [2:0][W-2:0] par_rm  [NP+1];
  logic [2:0]        par_qb  [1:NP];
  logic [2:0]        par_sgn [NP+1];
  logic [2:0][W-1:0] par_c   [NP+1];

  spc_round #(.W(W), .AW(AW)) u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (cut_ctl[ND]),
    .ar_i  (cut_ar[ND]),
    .aq_i  (cut_aq[ND]),
    .neg_i (cut_neg[ND]),
    .p_i   (cut_p[ND]),
    .ctl_o (par_ctl[0]),
    .c_o   (par_c[0]),
    .mag_o (par_u[0]),
    .sgn_o (par_sgn[0])
  );

  assign par_rm[0] = '0;

  // floor division by the square size, one quotient bit per stage
  for (genvar g = 0; g < NP; g++) begin : g_par
    spc_par_step #(.W(W)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sq    (sq_eff),
      .ctl_i (par_ctl[g]),
      .u_i   (par_u[g]),
      .r_i   (par_rm[g]),
      .sgn_i (par_sgn[g]),
      .c_i   (par_c[g]),
      .ctl_o (par_ctl[g+1]),
      .u_o   (par_u[g+1]),
      .r_o   (par_rm[g+1]),
      .qb_o  (par_qb[g+1]),
      .sgn_o (par_sgn[g+1]),
      .c_o   (par_c[g+1])
    );
  end

  // result register and skid
  logic              res_v_r, sk_v_r;
  logic [OUT_W-1:0]  res_r, sk_r, res_nxt;
  logic [2:0]        axis_par;
  logic              crossed, hit;
  logic [2:0][W-1:0] cross_pt;

  always_comb begin
    // a negative value with a remainder rounds down one more, flipping parity
    for (int i = 0; i < 3; i++) begin
      axis_par[i] = par_qb[NP][i] ^ (par_sgn[NP][i] && par_rm[NP][i] != '0);
      cross_pt[i] = par_ctl[NP].crossed ? par_c[NP][i] : '0;
    end
    crossed = par_ctl[NP].crossed;
    hit     = crossed && ((axis_par[0] ^ axis_par[1] ^ axis_par[2]) != par_r);
    res_nxt = OUT_W'({cz_r, cy_r, cx_r, cross_pt[2], cross_pt[1], cross_pt[0],
                      par_ctl[NP].start_inside, hit, crossed});
  end

  assign en = !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (en) begin
        res_v_r <= par_ctl[NP].valid;
      end
      if (sk_v_r) begin
        if (out_tready) begin
          sk_v_r <= 1'b0;
        end
      end else if (res_v_r && !out_tready) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
    if (!sk_v_r) begin
      sk_r <= res_r;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = sk_v_r || res_v_r;
  assign out_tdata  = sk_v_r ? sk_r : res_r;

endmodule

@@ hdl/spc_checker.sv @@
// port-level checks of the segment plane checker, bound to the top level
`include "segment_plane_checker_hit_assert.svh"

module spc_checker import spc_pkg::*; #(
  parameter int W  = COORD_WIDTH_DEF,
  parameter int OW = ((6*COORD_WIDTH_DEF+10)/8)*8
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [OW-1:0] out_tdata
);

  `SPC_ASSERT_NEXT(a_reset_idle, clk, 1'b1, !rst_n, !out_tvalid)
  `SPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SPC_ASSERT_NOW(a_hit_needs_cross, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0])
  `SPC_ASSERT_NOW(a_miss_clean, clk, rst_n, out_tvalid && !out_tdata[0], !out_tdata[1] && out_tdata[3 +: 3*W] == '0)

endmodule

bind segment_plane_checker_hit spc_checker #(
  .W  (COORD_WIDTH),
  .OW (((6*COORD_WIDTH+10)/8)*8)
) u_spc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/testbench.sv @@
// testbench for segment_plane_checker_hit: predicts every result and checks it in order
module testbench import spc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DRAIN_CYCLES = 2*CW + 16;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 200;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic           crossed;
    logic           hit;
    logic           start_inside;
    logic [CW-1:0]  cross_x, cross_y, cross_z;
    logic [CW-1:0]  normal_x, normal_y, normal_z;
  } hit_result_t;

  class hit_scoreboard;
    logic [CW-1:0] coef_x, coef_y, coef_z, offset;
    logic [CW-2:0] square_size;
    logic          hole_parity;
    hit_result_t   pending[$];
    int            errors;

    function new();
      coef_x = '0;
      coef_y = '0;
      coef_z = CW'(1) << FB;
      offset = '0;
      square_size = (CW-1)'(1) << FB;
      hole_parity = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
      case (cfg_idx_t'(idx))
        CFG_COEF_X:      coef_x = value;
        CFG_COEF_Y:      coef_y = value;
        CFG_COEF_Z:      coef_z = value;
        CFG_OFFSET:      offset = value;
        CFG_SQUARE_SIZE: square_size = value[CW-2:0];
        CFG_HOLE_PARITY: hole_parity = value[0];
        default: ;
      endcase
    endfunction

    function wide_t sx(logic [CW-1:0] v);
      wide_t w;
      w = $signed(v);
      return w;
    endfunction

    function wide_t plane_value(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
      wide_t acc;
      acc = sx(coef_x) * sx(x) + sx(coef_y) * sx(y) + sx(coef_z) * sx(z);
      acc = acc + (sx(offset) <<< FB);
      return acc;
    endfunction

    function wide_t wabs(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    // crossing coordinate truncated toward zero, then saturated
    function wide_t crossing_coord(logic [CW-1:0] p, logic [CW-1:0] q, wide_t a1, wide_t den);
      wide_t delta, prod, quot, rem, n;
      delta = sx(q) - sx(p);
      prod = wabs(delta) * a1;
      quot = prod / den;
      rem = prod % den;
      n = (delta < 0) ? sx(p) - quot : sx(p) + quot;
      if (rem != 0) begin
        if (delta >= 0 && n < 0) n = n + 1;
        if (delta < 0 && n > 0) n = n - 1;
      end
      if (n > sx({1'b0, {(CW-1){1'b1}}})) n = sx({1'b0, {(CW-1){1'b1}}});
      if (n < sx({1'b1, {(CW-1){1'b0}}})) n = sx({1'b1, {(CW-1){1'b0}}});
      return n;
    endfunction

    // parity of floor(v/s); the sign of the quotient does not change it
    function logic floor_parity(wide_t v, wide_t s);
      wide_t mag, quot;
      mag = wabs(v);
      quot = mag / s;
      if (v < 0 && (mag % s) != 0) quot = quot + 1;
      return quot[0];
    endfunction

    function void note_segment(logic [6*CW-1:0] seg);
      logic [CW-1:0] px, py, pz, qx, qy, qz;
      wide_t d1, d2, a1, den, s, x, y, z;
      hit_result_t r;
      {qz, qy, qx, pz, py, px} = seg;
      d1 = plane_value(px, py, pz);
      d2 = plane_value(qx, qy, qz);
      r.crossed = (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);
      r.start_inside = (d1 <= 0);
      r.hit = 1'b0;
      r.cross_x = '0;
      r.cross_y = '0;
      r.cross_z = '0;
      if (r.crossed) begin
        a1 = wabs(d1);
        den = a1 + wabs(d2);
        s = (square_size == 0) ? wide_t'(1) : wide_t'({1'b0, square_size});
        x = crossing_coord(px, qx, a1, den);
        y = crossing_coord(py, qy, a1, den);
        z = crossing_coord(pz, qz, a1, den);
        r.hit = (floor_parity(x, s) ^ floor_parity(y, s) ^ floor_parity(z, s)) != hole_parity;
        r.cross_x = x[CW-1:0];
        r.cross_y = y[CW-1:0];
        r.cross_z = z[CW-1:0];
      end
      r.normal_x = coef_x;
      r.normal_y = coef_y;
      r.normal_z = coef_z;
      pending.push_back(r);
    endfunction

    task report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_result(logic [6*CW+7:0] data);
      hit_result_t got, want;
      {got.normal_z, got.normal_y, got.normal_x, got.cross_z, got.cross_y, got.cross_x,
       got.start_inside, got.hit, got.crossed} = data[6*CW+2:0];
      if (pending.size() == 0) begin
        $display("unexpected result transfer %h", data);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.crossed !== want.crossed) report("crossed", got.crossed, want.crossed);
        if (got.hit !== want.hit) report("hit", got.hit, want.hit);
        if (got.start_inside !== want.start_inside)
          report("start_inside", got.start_inside, want.start_inside);
        if (got.cross_x !== want.cross_x) report("cross_x", got.cross_x, want.cross_x);
        if (got.cross_y !== want.cross_y) report("cross_y", got.cross_y, want.cross_y);
        if (got.cross_z !== want.cross_z) report("cross_z", got.cross_z, want.cross_z);
        if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
        if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
        if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [6*CW-1:0]      in_tdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [6*CW+7:0]      out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CW-1:0]        cfg_data = '0;

  int tx_idle_pct = 18;
  int rx_idle_pct = 87;
  int quiet_cycles = 0;
  hit_scoreboard sb = new();

  always #6 clk = ~clk;

  segment_plane_checker_hit dut (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready, .out_tdata, .out_tvalid, .out_tready,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_segment(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_data);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  task write_reg(cfg_idx_t idx, logic [CW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task send_segment(logic [CW-1:0] px, py, pz, qx, qy, qz);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {qz, qy, qx, pz, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  // lets the last input transfer be noted by the monitor before the queue is watched
  task wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic [CW-1:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'($urandom_range(0, 1 << 21)) - CW'(1 << 20);
      default: return CW'($urandom_range(0, 1 << 24)) - CW'(1 << 23);
    endcase
  endfunction

  // coordinates: mostly within a few hundred units so checker squares vary
  function logic [CW-1:0] rand_coord();
    case ($urandom_range(7))
      0: return $urandom;
      1: return ($urandom_range(1)) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      2: return CW'($urandom_range(0, 8)) << FB;
      default: return CW'($urandom_range(0, 1 << 25)) - CW'(1 << 24);
    endcase
  endfunction

  task random_config();
    write_reg(CFG_COEF_X, rand_value());
    write_reg(CFG_COEF_Y, rand_value());
    write_reg(CFG_COEF_Z, rand_value());
    write_reg(CFG_OFFSET, rand_value());
    case ($urandom_range(4))
      0: write_reg(CFG_SQUARE_SIZE, '0);
      1: write_reg(CFG_SQUARE_SIZE, {1'b0, {(CW-1){1'b1}}});
      2: write_reg(CFG_SQUARE_SIZE, $urandom);
      default: write_reg(CFG_SQUARE_SIZE, CW'($urandom_range(1, 1 << 20)));
    endcase
    write_reg(CFG_HOLE_PARITY, CW'($urandom_range(1)));
  endtask

  initial begin
    logic [CW-1:0] one, mx, mn;
    one = CW'(1) << FB;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default plane z = 0, unit squares
    send_segment(0, 0, one, 0, 0, -one);
    send_segment(0, 0, 0, 0, 0, -one);
    send_segment(0, 0, one, 0, 0, 0);
    send_segment(one, one, one, 2*one, one, 3*one);
    send_segment(-one, -one, -one, -2*one, one, -one);
    send_segment(mx, mn, mx, mn, mx, mn);
    send_segment(mn, mn, mn, mx, mx, mx);
    send_segment(-(one + one/2), -(2*one + one/2), 3*one, -one/2, -(3*one + one/2), -one);
    send_segment(one/3, -one/7, one, -5*one, 3*one, -one);
    send_segment(0, 0, 1, 0, 0, -1);
    wait_idle();

    // extreme registers
    write_reg(CFG_COEF_X, mx);
    write_reg(CFG_COEF_Y, mn);
    write_reg(CFG_COEF_Z, mn);
    write_reg(CFG_OFFSET, mx);
    write_reg(CFG_SQUARE_SIZE, '0);
    write_reg(CFG_HOLE_PARITY, 1);
    send_segment(mx, mn, mx, mn, mx, mn);
    send_segment(0, 0, 0, mx, mx, mx);
    send_segment(mn, mx, mx, 0, 0, 0);
    send_segment(one, -one, one, -one, one, -one);
    wait_idle();
    write_reg(CFG_COEF_X, mn);
    write_reg(CFG_COEF_Y, mx);
    write_reg(CFG_COEF_Z, mx);
    write_reg(CFG_OFFSET, mn);
    write_reg(CFG_SQUARE_SIZE, mx);
    write_reg(CFG_HOLE_PARITY, 0);
    send_segment(mx, mn, mx, mn, mx, mn);
    send_segment(mn, mn, mn, mx, mx, mx);
    send_segment(-one, 2*one, -3*one, 4*one, -5*one, 6*one);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 87 : 0;
      rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) begin
          wait_idle();
          random_config();
        end
        // endpoints drawn independently, so segments often straddle the plane
        send_segment(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
      end
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
